[hdl/tme_pkg.sv]
// Shared types, widths and opcode constants for the toy memory ISA executor.
`timescale 1ns / 1ps
`default_nettype none

package tme_pkg;

    localparam int DATA_W    = 32;
    localparam int PC_W      = 11;
    localparam int VAR_IDX_W = 6;
    localparam int LIT_W     = 31;
    localparam int OPC_W     = 4;
    localparam int STEP_W    = 5;

    // Opcodes
    localparam logic [OPC_W-1:0] OP_HALT  = 4'd0;
    localparam logic [OPC_W-1:0] OP_PRINT = 4'd1;
    localparam logic [OPC_W-1:0] OP_SET   = 4'd2;
    localparam logic [OPC_W-1:0] OP_ADD   = 4'd3;
    localparam logic [OPC_W-1:0] OP_SUB   = 4'd4;
    localparam logic [OPC_W-1:0] OP_MUL   = 4'd5;
    localparam logic [OPC_W-1:0] OP_DIV   = 4'd6;
    localparam logic [OPC_W-1:0] OP_JMP   = 4'd7;
    localparam logic [OPC_W-1:0] OP_JZ    = 4'd8;

    // Last step of a multiply or divide sweep
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

    typedef struct packed {
        logic [OPC_W-1:0]     opcode;
        logic                 first_is_literal;
        logic [LIT_W-1:0]     first_literal;
        logic [VAR_IDX_W-1:0] first_variable;
        logic                 second_is_literal;
        logic [LIT_W-1:0]     second_literal;
        logic [VAR_IDX_W-1:0] second_variable;
    } tme_instr_t;

    typedef struct packed {
        logic [PC_W-1:0]          next_pc;
        logic                     print_valid;
        logic signed [DATA_W-1:0] print_value;
        logic                     halted;
        logic                     finished;
        logic                     divide_by_zero;
        logic                     unknown_opcode;
    } tme_result_t;

    typedef logic [PC_W-1:0] tme_cfg_t;

    // Request to the shared adder/subtractor
    typedef struct packed {
        logic [DATA_W-1:0] op_a;
        logic [DATA_W-1:0] op_b;
        logic              subtract;
    } tme_alu_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] sum;
        logic              carry;
    } tme_alu_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ_A,
        S_READ_B,
        S_EXEC,
        S_MUL_STEP,
        S_DIV_NEGB,
        S_DIV_STEP,
        S_DIV_FIX,
        S_COMMIT,
        S_FINISH
    } tme_state_t;

endpackage

`default_nettype wire

[hdl/tme_stream_if.sv]
// Valid/ready channel carrying one request payload.
`timescale 1ns / 1ps
`default_nettype none

interface tme_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/tme_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/tme_alu.sv]
// Shared 32-bit adder/subtractor with carry out, used by every arithmetic step.
`timescale 1ns / 1ps
`default_nettype none

module tme_alu
    import tme_pkg::*;
(
    input  wire tme_alu_req_t req,
    output tme_alu_rsp_t      rsp
);

    logic [DATA_W-1:0] operand_b;
    logic [DATA_W:0]   total;

    // Invert and add one for subtraction; carry set means no borrow
    assign operand_b = req.subtract ? ~req.op_b : req.op_b;
    assign total     = {1'b0, req.op_a} + {1'b0, operand_b} + (DATA_W + 1)'(req.subtract);
    assign rsp.sum   = total[DATA_W-1:0];
    assign rsp.carry = total[DATA_W];

endmodule

`default_nettype wire

[hdl/tme_core.sv]
// Instruction sequencer: operand fetch, iterative multiply/divide, commit and result register.
`timescale 1ns / 1ps
`default_nettype none

module tme_core
    import tme_pkg::*;
#(
    parameter int NUM_VARIABLES = 64,
    parameter int PROGRAM_DEPTH = 1024,
    parameter int NUM_STORE     = 64,
    parameter int SA            = 6
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    tme_stream_if.sink         instr,
    tme_stream_if.source       result,
    tme_stream_if.sink         cfg,
    output logic               ram_we,
    output logic [SA-1:0]      ram_waddr,
    output logic [DATA_W-1:0]  ram_wdata,
    output logic               ram_re,
    output logic [SA-1:0]      ram_raddr,
    input  wire logic [DATA_W-1:0] ram_rdata,
    output tme_alu_req_t       alu_req,
    input  wire tme_alu_rsp_t  alu_rsp
);

    localparam logic [DATA_W-1:0] NUM_VARS_W = DATA_W'(NUM_VARIABLES);
    localparam int MAX_LEN       = 2 ** PC_W - 1;
    localparam int DEPTH_CAP_INT = (PROGRAM_DEPTH > MAX_LEN) ? MAX_LEN : PROGRAM_DEPTH;
    localparam logic [PC_W-1:0] DEPTH_CAP = PC_W'(DEPTH_CAP_INT);

    typedef struct packed {
        logic wr;
        logic print;
        logic halt;
        logic dz;
        logic unk;
        logic jump;
    } flags_t;

    tme_state_t        state_reg,   state_next;
    tme_instr_t        ins_reg,     ins_next;
    logic [DATA_W-1:0] cur_reg,     cur_next;
    logic [DATA_W-1:0] b_reg,       b_next;
    logic [DATA_W-1:0] acc_reg,     acc_next;
    logic [DATA_W-1:0] aux_reg,     aux_next;
    logic [DATA_W-1:0] mop_reg,     mop_next;
    logic [STEP_W-1:0] cnt_reg,     cnt_next;
    logic              negq_reg,    negq_next;
    logic              rd_ok_reg,   rd_ok_next;
    flags_t            flags_reg,   flags_next;
    logic [PC_W-1:0]   pc_reg,      pc_next;
    logic              stopped_reg, stopped_next;
    logic [PC_W-1:0]   len_reg,     len_next;
    logic [NUM_STORE-1:0] valid_reg, valid_next;
    tme_result_t       pend_reg,    pend_next;
    tme_result_t       out_reg,     out_next;
    logic              out_valid_reg, out_valid_next;

    logic [DATA_W-1:0] a_value;
    logic [PC_W-1:0]   pc_plus;
    logic [PC_W-1:0]   cfg_len;
    logic              jump_out;
    logic [DATA_W-1:0] rem_shift;
    logic [DATA_W-1:0] quo_shift;
    logic [PC_W-1:0]   commit_pc;
    logic              commit_fin;

    function automatic logic in_range(input logic [VAR_IDX_W-1:0] idx);
        in_range = DATA_W'(idx) < NUM_VARS_W;
    endfunction

    function automatic logic var_ok(input logic [VAR_IDX_W-1:0] idx,
                                    input logic [NUM_STORE-1:0] vbits);
        var_ok = in_range(idx) && vbits[idx[SA-1:0]];
    endfunction

    assign instr.ready = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // First operand and pc helpers
    assign a_value  = ins_reg.first_is_literal ? {1'b0, ins_reg.first_literal} : cur_reg;
    assign pc_plus  = pc_reg + PC_W'(1);
    assign cfg_len  = (cfg.data > DEPTH_CAP) ? DEPTH_CAP : cfg.data;
    assign jump_out = acc_reg[DATA_W-1] || (acc_reg[DATA_W-1:PC_W] != '0)
                      || (acc_reg[PC_W-1:0] >= len_reg);
    assign rem_shift = {acc_reg[DATA_W-2:0], aux_reg[DATA_W-1]};
    assign quo_shift = {aux_reg[DATA_W-2:0], 1'b0};

    // Resolve the next pc and the end-of-run flag at commit
    always_comb
    begin
        commit_pc  = pc_plus;
        commit_fin = (pc_plus >= len_reg);
        if (flags_reg.halt)
        begin
            commit_pc  = pc_reg;
            commit_fin = 1'b0;
        end
        else if (flags_reg.jump)
        begin
            commit_pc  = jump_out ? len_reg : acc_reg[PC_W-1:0];
            commit_fin = jump_out;
        end
    end

    // Sequencer: next state and datapath controls
    always_comb
    begin
        state_next     = state_reg;
        ins_next       = ins_reg;
        cur_next       = cur_reg;
        b_next         = b_reg;
        acc_next       = acc_reg;
        aux_next       = aux_reg;
        mop_next       = mop_reg;
        cnt_next       = cnt_reg;
        negq_next      = negq_reg;
        rd_ok_next     = rd_ok_reg;
        flags_next     = flags_reg;
        pc_next        = pc_reg;
        stopped_next   = stopped_reg;
        len_next       = len_reg;
        valid_next     = valid_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result.ready;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        ram_we         = 1'b0;
        ram_waddr      = ins_reg.first_variable[SA-1:0];
        ram_wdata      = acc_reg;
        alu_req        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (instr.valid)
                begin
                    ins_next = instr.data;
                    if (stopped_reg || (pc_reg >= len_reg))
                    begin
                        // Ignore the request: the run is already over
                        stopped_next = 1'b1;
                        pend_next    = '{next_pc: pc_reg, print_valid: 1'b0,
                                         print_value: '0, halted: 1'b0, finished: 1'b1,
                                         divide_by_zero: 1'b0, unknown_opcode: 1'b0};
                        state_next   = S_FINISH;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = instr.data.first_variable[SA-1:0];
                        rd_ok_next = var_ok(instr.data.first_variable, valid_reg);
                        state_next = S_READ_A;
                    end
                end
            end

            S_READ_A:
            begin
                // Take the destination's value, fetch the second variable
                cur_next   = rd_ok_reg ? ram_rdata : '0;
                ram_re     = 1'b1;
                ram_raddr  = ins_reg.second_variable[SA-1:0];
                rd_ok_next = var_ok(ins_reg.second_variable, valid_reg);
                state_next = S_READ_B;
            end

            S_READ_B:
            begin
                if (ins_reg.second_is_literal)
                begin
                    b_next = {1'b0, ins_reg.second_literal};
                end
                else
                begin
                    b_next = rd_ok_reg ? ram_rdata : '0;
                end
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                flags_next = '0;
                state_next = S_COMMIT;
                case (ins_reg.opcode)
                    OP_HALT:
                    begin
                        flags_next.halt = 1'b1;
                    end
                    OP_PRINT:
                    begin
                        flags_next.print = 1'b1;
                        acc_next         = a_value;
                    end
                    OP_SET:
                    begin
                        flags_next.wr = 1'b1;
                        acc_next      = b_reg;
                    end
                    OP_ADD, OP_SUB:
                    begin
                        alu_req.op_a     = cur_reg;
                        alu_req.op_b     = b_reg;
                        alu_req.subtract = (ins_reg.opcode == OP_SUB);
                        flags_next.wr    = 1'b1;
                        acc_next         = alu_rsp.sum;
                    end
                    OP_MUL:
                    begin
                        flags_next.wr = 1'b1;
                        acc_next      = '0;
                        aux_next      = cur_reg;
                        mop_next      = b_reg;
                        cnt_next      = '0;
                        state_next    = S_MUL_STEP;
                    end
                    OP_DIV:
                    begin
                        if (b_reg == '0)
                        begin
                            flags_next.dz = 1'b1;
                        end
                        else
                        begin
                            // Take the dividend's magnitude
                            alu_req.op_a     = '0;
                            alu_req.op_b     = cur_reg;
                            alu_req.subtract = 1'b1;
                            aux_next         = cur_reg[DATA_W-1] ? alu_rsp.sum : cur_reg;
                            negq_next        = cur_reg[DATA_W-1] ^ b_reg[DATA_W-1];
                            flags_next.wr    = 1'b1;
                            state_next       = S_DIV_NEGB;
                        end
                    end
                    OP_JMP:
                    begin
                        flags_next.jump = 1'b1;
                        acc_next        = a_value;
                    end
                    OP_JZ:
                    begin
                        flags_next.jump = (a_value == '0);
                        acc_next        = b_reg;
                    end
                    default:
                    begin
                        flags_next.unk = 1'b1;
                    end
                endcase
            end

            S_MUL_STEP:
            begin
                // Shift and add one multiplier bit
                alu_req.op_a = acc_reg;
                alu_req.op_b = aux_reg;
                if (mop_reg[0])
                begin
                    acc_next = alu_rsp.sum;
                end
                aux_next = {aux_reg[DATA_W-2:0], 1'b0};
                mop_next = {1'b0, mop_reg[DATA_W-1:1]};
                cnt_next = cnt_reg + STEP_W'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = S_COMMIT;
                end
            end

            S_DIV_NEGB:
            begin
                // Take the divisor's magnitude, clear the remainder
                alu_req.op_a     = '0;
                alu_req.op_b     = b_reg;
                alu_req.subtract = 1'b1;
                mop_next         = b_reg[DATA_W-1] ? alu_rsp.sum : b_reg;
                acc_next         = '0;
                cnt_next         = '0;
                state_next       = S_DIV_STEP;
            end

            S_DIV_STEP:
            begin
                // Restoring step: trial subtract of the divisor
                alu_req.op_a     = rem_shift;
                alu_req.op_b     = mop_reg;
                alu_req.subtract = 1'b1;
                if (alu_rsp.carry)
                begin
                    acc_next = alu_rsp.sum;
                    aux_next = quo_shift | DATA_W'(1);
                end
                else
                begin
                    acc_next = rem_shift;
                    aux_next = quo_shift;
                end
                cnt_next = cnt_reg + STEP_W'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = S_DIV_FIX;
                end
            end

            S_DIV_FIX:
            begin
                // Apply the quotient's sign
                alu_req.op_a     = '0;
                alu_req.op_b     = aux_reg;
                alu_req.subtract = 1'b1;
                acc_next         = negq_reg ? alu_rsp.sum : aux_reg;
                state_next       = S_COMMIT;
            end

            S_COMMIT:
            begin
                // Write back the variable and advance the pc
                if (flags_reg.wr && in_range(ins_reg.first_variable))
                begin
                    ram_we = 1'b1;
                    valid_next[ins_reg.first_variable[SA-1:0]] = 1'b1;
                end
                pc_next      = commit_pc;
                stopped_next = flags_reg.halt || commit_fin;
                pend_next    = '{next_pc: commit_pc, print_valid: flags_reg.print,
                                 print_value: flags_reg.print ? acc_reg : '0,
                                 halted: flags_reg.halt, finished: commit_fin,
                                 divide_by_zero: flags_reg.dz,
                                 unknown_opcode: flags_reg.unk};
                state_next   = S_FINISH;
            end

            S_FINISH:
            begin
                // Hold until the result register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
        endcase

        // Load a new program length
        if (cfg.valid)
        begin
            len_next     = cfg_len;
            pc_next      = '0;
            stopped_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            stopped_reg   <= 1'b0;
            len_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
            cnt_reg       <= '0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            stopped_reg   <= stopped_next;
            len_reg       <= len_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            flags_reg     <= flags_next;
            cnt_reg       <= cnt_next;
            rd_ok_reg     <= rd_ok_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        ins_reg  <= ins_next;
        cur_reg  <= cur_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        aux_reg  <= aux_next;
        mop_reg  <= mop_next;
        negq_reg <= negq_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire

[hdl/toy_memory_isa_executor.sv]
// Top level of the toy memory ISA executor: sequencer, variable RAM and shared ALU.
//
// Channels: instr takes one decoded instruction per request, result returns
// exactly one result request per instruction, cfg writes the program length
// (which also restarts the run at pc zero and keeps the variables).
// The sequencer walks through operand fetch on the single RAM read port and
// the one shared adder/subtractor: MUL runs 32 shift-add steps, DIV runs two
// sign steps, 32 restoring steps and one sign fix, and an instruction after
// the run has ended goes straight to the finish state. That state loads the
// result into the output register. instr is not ready while an instruction
// is in progress; a held result does not block the next acceptance, only the
// delivery of the next result. Reset clears the pc, the stop flag, the length
// and the valid bits of the variable store, so every variable reads as zero
// until written.
`timescale 1ns / 1ps
`default_nettype none

module toy_memory_isa_executor
    import tme_pkg::*;
#(
    parameter int NUM_VARIABLES = 64,
    parameter int PROGRAM_DEPTH = 1024
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    tme_stream_if.sink   instr,
    tme_stream_if.source result,
    tme_stream_if.sink   cfg
);

    // Only indices reachable by the 6-bit operand fields get storage
    localparam int REACH     = 2 ** VAR_IDX_W;
    localparam int NUM_STORE = (NUM_VARIABLES < REACH) ? NUM_VARIABLES : REACH;
    localparam int SA        = $clog2(NUM_STORE);

    logic              ram_we;
    logic [SA-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [SA-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    tme_alu_req_t      alu_req;
    tme_alu_rsp_t      alu_rsp;

    tme_core #(
        .NUM_VARIABLES (NUM_VARIABLES),
        .PROGRAM_DEPTH (PROGRAM_DEPTH),
        .NUM_STORE     (NUM_STORE),
        .SA            (SA)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .instr     (instr),
        .result    (result),
        .cfg       (cfg),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .alu_req   (alu_req),
        .alu_rsp   (alu_rsp)
    );

    tme_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_STORE)
    ) u_var_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tme_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

endmodule

`default_nettype wire

[sim/toy_memory_isa_executor_tb.sv]
// Self-checking testbench for the toy memory ISA executor: directed table, then random programs.
`timescale 1ns / 1ps

module toy_memory_isa_executor_tb
    import tme_pkg::*;
();

    localparam int NUM_VARS      = 64;
    localparam int PROG_DEPTH    = 1024;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int NOISE_PCT     = 15;
    localparam int LONG_STALL    = 400;
    localparam int TAIL_CYCLES   = 60;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [LIT_W-1:0]     LIT_MAX          = {LIT_W{1'b1}};
    localparam logic [VAR_IDX_W-1:0] VAR_LAST         = {VAR_IDX_W{1'b1}};
    localparam logic [OPC_W-1:0]     OP_FIRST_UNKNOWN = 4'd9;
    localparam logic [OPC_W-1:0]     OP_LAST_UNKNOWN  = 4'd15;

    typedef enum logic {ROW_LOAD, ROW_STEP} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        tme_cfg_t    load_value;
        tme_instr_t  instr;
        bit          fixed;
        tme_result_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    tme_stream_if #(.payload_t(tme_instr_t))  instr_ch ();
    tme_stream_if #(.payload_t(tme_result_t)) result_ch ();
    tme_stream_if #(.payload_t(tme_cfg_t))    cfg_ch ();

    toy_memory_isa_executor #(
        .NUM_VARIABLES(NUM_VARS),
        .PROGRAM_DEPTH(PROG_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Predictor state: a private copy of the store, pc, stop flag and length
    logic [DATA_W-1:0] pred_vars [NUM_VARS];
    logic [31:0]       pred_pc;
    bit                pred_stopped;
    tme_cfg_t          prog_length;

    tme_result_t expected_results [$];
    stim_row_t   directed_rows [$];
    tme_result_t head_result;

    int tx_idle_pct;
    int rx_idle_pct;
    bit stall_request;
    int stall_left;
    int failures;
    int cycle_count;
    int results_checked;
    int executed;
    int ignored;
    int loads;
    int prints;
    int halts;
    int run_ends;
    int zero_divides;
    int unknowns;
    int rand_live;
    int phase_len;
    int phase_count;
    int pick;
    bit stall_fired;
    bit pause_fired;
    tme_cfg_t new_length;

    // Clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("toy_memory_isa_executor regression: fail");
            $finish;
        end
    end

    function automatic logic [31:0] run_length();
        return (prog_length < PROG_DEPTH) ? 32'(prog_length) : 32'(PROG_DEPTH);
    endfunction

    // Execute one instruction against the private state and return its result
    function automatic tme_result_t predict_step(input tme_instr_t it);
        tme_result_t r;
        logic [31:0] lim;
        logic [31:0] nxt;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] cur;
        logic [31:0] target;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        logic [31:0] quot;
        bit          jump;
        r      = '0;
        jump   = 1'b0;
        target = '0;
        lim    = run_length();
        nxt    = pred_pc + 1;
        if (pred_stopped || pred_pc >= lim)
        begin
            pred_stopped = 1'b1;
            nxt          = pred_pc;
            r.finished   = 1'b1;
        end
        else
        begin
            a   = it.first_is_literal ? {1'b0, it.first_literal} : pred_vars[it.first_variable];
            b   = it.second_is_literal ? {1'b0, it.second_literal}
                                       : pred_vars[it.second_variable];
            cur = pred_vars[it.first_variable];
            case (it.opcode)
                OP_HALT:
                begin
                    r.halted     = 1'b1;
                    pred_stopped = 1'b1;
                    nxt          = pred_pc;
                end
                OP_PRINT:
                begin
                    r.print_valid = 1'b1;
                    r.print_value = a;
                end
                OP_SET: pred_vars[it.first_variable] = b;
                OP_ADD: pred_vars[it.first_variable] = cur + b;
                OP_SUB: pred_vars[it.first_variable] = cur - b;
                OP_MUL: pred_vars[it.first_variable] = cur * b;
                OP_DIV:
                begin
                    // Truncate toward zero on magnitudes, then restore the sign
                    if (b == 0)
                    begin
                        r.divide_by_zero = 1'b1;
                    end
                    else
                    begin
                        mag_a = cur[31] ? (32'd0 - cur) : cur;
                        mag_b = b[31] ? (32'd0 - b) : b;
                        quot  = mag_a / mag_b;
                        pred_vars[it.first_variable] = (cur[31] != b[31]) ? (32'd0 - quot)
                                                                          : quot;
                    end
                end
                OP_JMP:
                begin
                    jump   = 1'b1;
                    target = a;
                end
                OP_JZ:
                begin
                    if (a == 0)
                    begin
                        jump   = 1'b1;
                        target = b;
                    end
                end
                default: r.unknown_opcode = 1'b1;
            endcase
            if (jump)
            begin
                if (target[31] || target >= lim)
                begin
                    nxt        = lim;
                    r.finished = 1'b1;
                end
                else
                begin
                    nxt = target;
                end
            end
            else if (!r.halted && nxt >= lim)
            begin
                r.finished = 1'b1;
            end
            if (r.finished)
                pred_stopped = 1'b1;
            pred_pc = nxt;
        end
        r.next_pc = nxt[PC_W-1:0];
        return r;
    endfunction

    function automatic tme_instr_t make_instr(input logic [OPC_W-1:0] opc,
                                              input logic fl, input logic [LIT_W-1:0] flit,
                                              input logic [VAR_IDX_W-1:0] fvar,
                                              input logic sl, input logic [LIT_W-1:0] slit,
                                              input logic [VAR_IDX_W-1:0] svar);
        tme_instr_t it;
        it.opcode            = opc;
        it.first_is_literal  = fl;
        it.first_literal     = flit;
        it.first_variable    = fvar;
        it.second_is_literal = sl;
        it.second_literal    = slit;
        it.second_variable   = svar;
        return it;
    endfunction

    function automatic tme_result_t make_result(input logic [PC_W-1:0] pc, input logic pv,
                                                input logic [DATA_W-1:0] pval, input logic halt,
                                                input logic fin, input logic dz,
                                                input logic unk);
        tme_result_t r;
        r.next_pc        = pc;
        r.print_valid    = pv;
        r.print_value    = pval;
        r.halted         = halt;
        r.finished       = fin;
        r.divide_by_zero = dz;
        r.unknown_opcode = unk;
        return r;
    endfunction

    function automatic void add_load(input tme_cfg_t value);
        stim_row_t row;
        row.kind       = ROW_LOAD;
        row.load_value = value;
        row.instr      = '0;
        row.fixed      = 1'b0;
        row.want       = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_step(input tme_instr_t it);
        stim_row_t row;
        row.kind       = ROW_STEP;
        row.load_value = '0;
        row.instr      = it;
        row.fixed      = 1'b0;
        row.want       = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_checked(input tme_instr_t it, input tme_result_t r);
        stim_row_t row;
        row.kind       = ROW_STEP;
        row.load_value = '0;
        row.instr      = it;
        row.fixed      = 1'b1;
        row.want       = r;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [VAR_IDX_W-1:0] random_variable();
        // Favour a small pool so that results feed later instructions
        if ($urandom_range(0, 3) == 0)
            return VAR_IDX_W'($urandom_range(0, VAR_LAST));
        return VAR_IDX_W'($urandom_range(0, 7));
    endfunction

    function automatic logic [LIT_W-1:0] random_literal();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return LIT_W'(1);
            2:       return LIT_MAX;
            3, 4:    return LIT_W'($urandom_range(0, 100));
            default: return LIT_W'($urandom);
        endcase
    endfunction

    // Build one instruction: mostly well formed for the current program, some noise
    function automatic tme_instr_t random_instr();
        tme_instr_t  it;
        int unsigned sel;
        logic [31:0] lim;
        lim                  = run_length();
        it.first_is_literal  = 1'($urandom_range(0, 1));
        it.first_literal     = random_literal();
        it.first_variable    = random_variable();
        it.second_is_literal = 1'($urandom_range(0, 1));
        it.second_literal    = random_literal();
        it.second_variable   = random_variable();
        if ($urandom_range(0, 99) < NOISE_PCT)
        begin
            it.opcode          = OPC_W'($urandom_range(0, OP_LAST_UNKNOWN));
            it.first_literal   = LIT_W'($urandom);
            it.second_literal  = LIT_W'($urandom);
            it.first_variable  = VAR_IDX_W'($urandom);
            it.second_variable = VAR_IDX_W'($urandom);
            return it;
        end
        sel = $urandom_range(0, 99);
        if (sel < 3)
            it.opcode = OP_HALT;
        else if (sel < 15)
            it.opcode = OP_PRINT;
        else if (sel < 27)
            it.opcode = OP_SET;
        else if (sel < 40)
            it.opcode = OP_ADD;
        else if (sel < 52)
            it.opcode = OP_SUB;
        else if (sel < 64)
            it.opcode = OP_MUL;
        else if (sel < 76)
        begin
            it.opcode = OP_DIV;
            if ($urandom_range(0, 9) == 0)
            begin
                it.second_is_literal = 1'b1;
                it.second_literal    = '0;
            end
        end
        else if (sel < 86)
        begin
            it.opcode = OP_JMP;
            if (lim > 0 && $urandom_range(0, 9) != 0)
            begin
                it.first_is_literal = 1'b1;
                it.first_literal    = LIT_W'($urandom_range(0, lim - 1));
            end
        end
        else if (sel < 97)
        begin
            it.opcode = OP_JZ;
            if ($urandom_range(0, 1) == 0)
            begin
                it.first_is_literal = 1'b1;
                it.first_literal    = '0;
            end
            if (lim > 0 && $urandom_range(0, 9) != 0)
            begin
                it.second_is_literal = 1'b1;
                it.second_literal    = LIT_W'($urandom_range(0, lim - 1));
            end
        end
        else
        begin
            it.opcode = OPC_W'($urandom_range(OP_FIRST_UNKNOWN, OP_LAST_UNKNOWN));
        end
        return it;
    endfunction

    // Hold the instruction channel idle until every result is back
    task automatic wait_drained();
        instr_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Load a new program length while the block is idle
    task automatic load_program(input tme_cfg_t value);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        prog_length  = value;
        pred_pc      = '0;
        pred_stopped = 1'b0;
        loads++;
    endtask

    // Offer one instruction request, then predict its result on acceptance
    task automatic send_instr(input tme_instr_t it, input bit fixed, input tme_result_t want);
        tme_result_t predicted;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            instr_ch.valid <= 1'b0;
            @(posedge clk);
        end
        instr_ch.valid <= 1'b1;
        instr_ch.data  <= it;
        do @(posedge clk); while (!instr_ch.ready);
        if (pred_stopped || pred_pc >= run_length())
            ignored++;
        else
            executed++;
        predicted = predict_step(it);
        expected_results.push_back(fixed ? want : predicted);
        if (predicted.print_valid)
            prints++;
        if (predicted.halted)
            halts++;
        if (predicted.finished)
            run_ends++;
        if (predicted.divide_by_zero)
            zero_divides++;
        if (predicted.unknown_opcode)
            unknowns++;
    endtask

    // Result sink: check each accepted request, then choose the next ready
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("unexpected result: pc=%0d pv=%0b pval=%0d",
                                 result_ch.data.next_pc, result_ch.data.print_valid,
                                 result_ch.data.print_value);
                end
                else
                begin
                    head_result = expected_results.pop_front();
                    results_checked++;
                    if (result_ch.data !== head_result)
                    begin
                        failures++;
                        if (failures <= REPORT_LIMIT)
                            $display({"result %0d mismatch: expected pc=%0d pv=%0b pval=%0d ",
                                      "halt=%0b fin=%0b dz=%0b unk=%0b, got pc=%0d pv=%0b ",
                                      "pval=%0d halt=%0b fin=%0b dz=%0b unk=%0b"},
                                     results_checked,
                                     head_result.next_pc, head_result.print_valid,
                                     head_result.print_value, head_result.halted,
                                     head_result.finished, head_result.divide_by_zero,
                                     head_result.unknown_opcode,
                                     result_ch.data.next_pc, result_ch.data.print_valid,
                                     result_ch.data.print_value, result_ch.data.halted,
                                     result_ch.data.finished, result_ch.data.divide_by_zero,
                                     result_ch.data.unknown_opcode);
                    end
                end
            end
            if (stall_request)
            begin
                stall_left    = LONG_STALL;
                stall_request = 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial
    begin
        rst_n           <= 1'b0;
        instr_ch.valid  <= 1'b0;
        instr_ch.data   <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.data     <= '0;
        for (int i = 0; i < NUM_VARS; i++)
            pred_vars[i] = '0;
        pred_pc       = '0;
        pred_stopped  = 1'b0;
        prog_length   = '0;
        tx_idle_pct   = 12;
        rx_idle_pct   = 64;
        stall_request = 1'b0;
        stall_fired   = 1'b0;
        pause_fired   = 1'b0;
        rand_live     = 0;
        phase_count   = 0;

        // Directed table: reset state, extremes, wrap, overflow, error flags, run ends
        add_checked(make_instr(OP_SET, 1'b0, '0, 6'd0, 1'b1, LIT_MAX, '0),
                    make_result(11'd0, 1'b0, '0, 1'b0, 1'b1, 1'b0, 1'b0));
        add_load(11'd2047);
        add_checked(make_instr(OP_SET, 1'b0, '0, 6'd0, 1'b1, LIT_MAX, '0),
                    make_result(11'd1, 1'b0, '0, 1'b0, 1'b0, 1'b0, 1'b0));
        add_step(make_instr(OP_ADD, 1'b0, '0, 6'd0, 1'b1, LIT_W'(1), '0));
        add_checked(make_instr(OP_PRINT, 1'b0, '0, 6'd0, 1'b0, '0, '0),
                    make_result(11'd3, 1'b1, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b0));
        add_step(make_instr(OP_SET, 1'b0, '0, VAR_LAST, 1'b1, '0, '0));
        add_step(make_instr(OP_SUB, 1'b0, '0, VAR_LAST, 1'b1, LIT_W'(1), '0));
        add_step(make_instr(OP_DIV, 1'b0, '0, 6'd0, 1'b0, '0, VAR_LAST));
        add_step(make_instr(OP_MUL, 1'b0, '0, 6'd0, 1'b0, '0, VAR_LAST));
        add_step(make_instr(OP_SET, 1'b0, '0, 6'd3, 1'b1, LIT_W'(7), '0));
        add_step(make_instr(OP_SET, 1'b0, '0, 6'd4, 1'b0, '0, VAR_LAST));
        add_step(make_instr(OP_ADD, 1'b0, '0, 6'd4, 1'b0, '0, VAR_LAST));
        add_step(make_instr(OP_DIV, 1'b0, '0, 6'd3, 1'b0, '0, 6'd4));
        add_step(make_instr(OP_PRINT, 1'b0, '0, 6'd3, 1'b0, '0, '0));
        add_checked(make_instr(OP_DIV, 1'b0, '0, 6'd5, 1'b1, '0, '0),
                    make_result(11'd13, 1'b0, '0, 1'b0, 1'b0, 1'b1, 1'b0));
        add_checked(make_instr(OP_FIRST_UNKNOWN, 1'b0, '0, '0, 1'b0, '0, '0),
                    make_result(11'd14, 1'b0, '0, 1'b0, 1'b0, 1'b0, 1'b1));
        add_checked(make_instr(OP_LAST_UNKNOWN, 1'b1, LIT_MAX, VAR_LAST, 1'b1, LIT_MAX,
                               VAR_LAST),
                    make_result(11'd15, 1'b0, '0, 1'b0, 1'b0, 1'b0, 1'b1));
        add_checked(make_instr(OP_PRINT, 1'b1, LIT_MAX, '0, 1'b0, '0, '0),
                    make_result(11'd16, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0));
        add_step(make_instr(OP_JZ, 1'b1, '0, '0, 1'b1, LIT_W'(1023), '0));
        add_checked(make_instr(OP_JMP, 1'b0, '0, VAR_LAST, 1'b0, '0, '0),
                    make_result(11'd1024, 1'b0, '0, 1'b0, 1'b1, 1'b0, 1'b0));
        add_checked(make_instr(OP_SET, 1'b0, '0, 6'd0, 1'b1, '0, '0),
                    make_result(11'd1024, 1'b0, '0, 1'b0, 1'b1, 1'b0, 1'b0));
        add_load(11'd3);
        add_checked(make_instr(OP_JMP, 1'b1, LIT_W'(3), '0, 1'b0, '0, '0),
                    make_result(11'd3, 1'b0, '0, 1'b0, 1'b1, 1'b0, 1'b0));
        add_load(11'd1024);
        add_checked(make_instr(OP_HALT, 1'b0, '0, '0, 1'b0, '0, '0),
                    make_result(11'd0, 1'b0, '0, 1'b1, 1'b0, 1'b0, 1'b0));
        add_checked(make_instr(OP_PRINT, 1'b1, LIT_MAX, '0, 1'b0, '0, '0),
                    make_result(11'd0, 1'b0, '0, 1'b0, 1'b1, 1'b0, 1'b0));
        add_load(11'd1);
        add_checked(make_instr(OP_JZ, 1'b0, '0, 6'd3, 1'b1, '0, '0),
                    make_result(11'd1, 1'b0, '0, 1'b0, 1'b1, 1'b0, 1'b0));
        add_load(11'd0);
        add_checked(make_instr(OP_ADD, 1'b0, '0, 6'd1, 1'b1, LIT_W'(1), '0),
                    make_result(11'd0, 1'b0, '0, 1'b0, 1'b1, 1'b0, 1'b0));

        // Release reset
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_LOAD)
                load_program(directed_rows[i].load_value);
            else
                send_instr(directed_rows[i].instr, directed_rows[i].fixed,
                           directed_rows[i].want);
        end

        // Random programs: load a length, then run a random number of instructions or until the program stops
        while (rand_live < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                new_length = '0;
            else if (pick < 10)
                new_length = 11'd1;
            else if (pick < 18)
                new_length = 11'd1024;
            else if (pick < 23)
                new_length = 11'd2047;
            else if (pick < 28)
                new_length = PC_W'($urandom_range(1025, 2046));
            else if (pick < 40)
                new_length = PC_W'($urandom_range(41, 1023));
            else
                new_length = PC_W'($urandom_range(2, 40));
            load_program(new_length);
            phase_count++;
            phase_len = $urandom_range(4, 60);
            for (int n = 0; n < phase_len && rand_live < RANDOM_ITEMS; n++)
            begin
                // Sender idles lightly first, then heavily, then not at all
                if (rand_live < RANDOM_ITEMS / 3)
                begin
                    tx_idle_pct = 12;
                    rx_idle_pct = 64;
                end
                else if (rand_live < 2 * RANDOM_ITEMS / 3)
                begin
                    tx_idle_pct = 64;
                    rx_idle_pct = 12;
                end
                else
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                if (pred_stopped || pred_pc >= run_length())
                begin
                    // Occasionally poke a stopped program
                    if ($urandom_range(0, 2) == 0)
                        send_instr(random_instr(), 1'b0, '0);
                    break;
                end
                send_instr(random_instr(), 1'b0, '0);
                rand_live++;
                if (!stall_fired && rand_live >= 200)
                begin
                    stall_fired   = 1'b1;
                    stall_request = 1'b1;
                end
                if (!pause_fired && rand_live >= 800)
                begin
                    pause_fired = 1'b1;
                    wait_drained();
                end
            end
        end

        // Drain and let the pipeline settle
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            failures += expected_results.size();
            $display("%0d results never arrived", expected_results.size());
        end

        $display("covered %0d instructions (%0d executed, %0d on a stopped program)",
                 executed + ignored, executed, ignored);
        $display("  over %0d loads and %0d random programs; checked %0d results:",
                 loads, phase_count, results_checked);
        $display("  %0d prints, %0d halts, %0d run ends, %0d zero divides, %0d unknown",
                 prints, halts, run_ends, zero_divides, unknowns);
        if (failures == 0)
            $display("toy_memory_isa_executor regression: pass");
        else
            $display("toy_memory_isa_executor regression: fail");
        $finish;
    end

endmodule
